[rtl/core/tcw_pkg.sv]
// Shared types and constants of the text console writer.
package tcw_pkg;

    localparam int FUNC_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int POS_W    = 12;
    localparam int CURSOR_W = 11;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_SET   = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;

    localparam logic [ATTR_W-1:0] FILL_ATTR_RESET = 8'd31;

    typedef enum logic [1:0] {
        SWEEP_INIT,
        SWEEP_CLEAR,
        SWEEP_SCROLL
    } sweep_kind_t;

    typedef struct packed {
        logic        capture;
        logic        put_exec;
        logic        set_apply;
        logic        sweep_run;
        sweep_kind_t sweep_kind;
        logic        scroll_dec;
        logic        result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sweep_last;
        logic scroll_need;
        logic scroll_more;
    } dp_status_t;

endpackage

[rtl/core/tcw_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/tcw_div.sv]
// Divider by a constant through a reciprocal multiplication: quotient first, then remainder.
module tcw_div import tcw_pkg::*; #(
    parameter int DIVISOR = 80,
    parameter int REM_W   = $clog2(DIVISOR)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    output logic             done,
    output logic [POS_W-1:0] quot,
    output logic [REM_W-1:0] rem
);

    // ceil(2^SHIFT / DIVISOR) is exact for every dividend below 2^POS_W
    localparam int SHIFT  = POS_W + $clog2(DIVISOR);
    localparam int MUL_W  = POS_W + 2;
    localparam int PROD_W = POS_W + MUL_W;
    localparam logic [MUL_W-1:0] RECIP = MUL_W'((2 ** SHIFT + DIVISOR - 1) / DIVISOR);

    logic [POS_W-1:0]  dvd_reg;
    logic [POS_W-1:0]  quot_reg;
    logic [REM_W-1:0]  rem_reg;
    logic              stage_reg;
    logic              done_reg;
    logic [PROD_W-1:0] prod;
    logic [POS_W-1:0]  back;
    logic [POS_W-1:0]  diff;

    always_comb
    begin
        prod = PROD_W'(dividend) * PROD_W'(RECIP);
        back = quot_reg * POS_W'(DIVISOR);
        diff = dvd_reg - back;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg && !start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            quot_reg <= POS_W'(prod >> SHIFT);
        end
        if (stage_reg)
        begin
            rem_reg <= diff[REM_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

[rtl/core/tcw_dp.sv]
// Datapath: cursor, screen memories, buffer sweep, row divider and result registers.
module tcw_dp import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [FUNC_W-1:0]   func,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [ATTR_W-1:0]   fill_color,
    input  logic [POS_W-1:0]    position,
    input  logic [ATTR_W-1:0]   scroll_fill_attr,
    output logic [CURSOR_W-1:0] cursor,
    output logic [CHAR_W-1:0]   cell_char,
    output logic [ATTR_W-1:0]   cell_attr,
    output logic                scrolled
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int BASE  = CELLS - COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CLW   = $clog2(COLUMNS);
    localparam logic [31:0] CELLS_W32 = 32'(CELLS);

    // captured item
    func_t             func_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [ATTR_W-1:0] color_reg;
    logic [POS_W-1:0]  pos_reg;

    // cursor and sweep state
    logic [AW-1:0]    cur_reg;
    logic [CLW-1:0]   col_reg;
    logic [AW-1:0]    idx_reg;
    logic             w_valid_reg;
    logic             w_copy_reg;
    logic [AW-1:0]    w_addr_reg;
    logic [POS_W-1:0] scroll_cnt_reg;
    logic             scrolled_reg;

    // result
    logic [CURSOR_W-1:0] cursor_reg;
    logic [CHAR_W-1:0]   cell_char_reg;
    logic [ATTR_W-1:0]   cell_attr_reg;
    logic                scrolled_out_reg;

    logic             div_start;
    logic             div_done;
    logic [POS_W-1:0] quot;
    logic [CLW-1:0]   rem;

    logic              is_lf;
    logic              is_cr;
    logic              last_row;
    logic              last_cell;
    logic              put_scroll;
    logic              set_scroll;
    logic              copy_now;
    logic              pos_in_range;
    logic [ATTR_W-1:0] fill_attr;

    logic              char_we;
    logic [AW-1:0]     char_waddr;
    logic [CHAR_W-1:0] char_wdata;
    logic [ATTR_W-1:0] attr_wdata;
    logic [AW-1:0]     raddr;
    logic [CHAR_W-1:0] char_rdata;
    logic [ATTR_W-1:0] attr_rdata;

    assign div_start = cmd.capture && (func_t'(func) == FUNC_SET);

    tcw_div #(
        .DIVISOR(COLUMNS),
        .REM_W  (CLW)
    ) u_tcw_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(position),
        .done    (div_done),
        .quot    (quot),
        .rem     (rem)
    );

    always_comb
    begin
        is_lf        = char_reg == CHAR_LF;
        is_cr        = char_reg == CHAR_CR;
        last_row     = cur_reg >= AW'(BASE);
        last_cell    = cur_reg == AW'(CELLS - 1);
        put_scroll   = is_lf ? last_row : (!is_cr && last_cell);
        set_scroll   = quot >= POS_W'(ROWS);
        copy_now     = (cmd.sweep_kind == SWEEP_SCROLL) && (idx_reg < AW'(BASE));
        pos_in_range = 32'(pos_reg) < CELLS_W32;

        unique case (cmd.sweep_kind)
            SWEEP_CLEAR:  fill_attr = color_reg;
            SWEEP_SCROLL: fill_attr = scroll_fill_attr;
            default:      fill_attr = '0;
        endcase

        status.div_done    = div_done;
        status.sweep_last  = idx_reg == AW'(CELLS - 1);
        status.scroll_need = (func_reg == FUNC_SET) ? set_scroll : put_scroll;
        status.scroll_more = scroll_cnt_reg > POS_W'(1);

        // sweep reads one row ahead of where it writes
        if (cmd.sweep_run)
        begin
            raddr = copy_now ? idx_reg + AW'(COLUMNS) : '0;
        end
        else
        begin
            raddr = pos_in_range ? AW'(pos_reg) : '0;
        end

        char_we    = (cmd.put_exec && !is_lf && !is_cr) || w_valid_reg;
        char_waddr = w_valid_reg ? w_addr_reg : cur_reg;
        if (w_valid_reg)
        begin
            char_wdata = w_copy_reg ? char_rdata : '0;
        end
        else
        begin
            char_wdata = char_reg;
        end
        attr_wdata = w_copy_reg ? attr_rdata : fill_attr;
    end

    tcw_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(CELLS)
    ) u_char_ram (
        .clk  (clk),
        .we   (char_we),
        .waddr(char_waddr),
        .wdata(char_wdata),
        .raddr(raddr),
        .rdata(char_rdata)
    );

    tcw_ram #(
        .WIDTH(ATTR_W),
        .DEPTH(CELLS)
    ) u_attr_ram (
        .clk  (clk),
        .we   (w_valid_reg),
        .waddr(w_addr_reg),
        .wdata(attr_wdata),
        .raddr(raddr),
        .rdata(attr_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= '0;
            col_reg        <= '0;
            idx_reg        <= '0;
            w_valid_reg    <= 1'b0;
            w_copy_reg     <= 1'b0;
            scroll_cnt_reg <= '0;
            scrolled_reg   <= 1'b0;
        end
        else
        begin
            w_valid_reg <= cmd.sweep_run;
            w_copy_reg  <= cmd.sweep_run && copy_now;
            if (cmd.sweep_run)
            begin
                idx_reg <= status.sweep_last ? '0 : idx_reg + AW'(1);
            end

            if (cmd.capture && (func_t'(func) == FUNC_CLEAR))
            begin
                cur_reg <= '0;
                col_reg <= '0;
            end
            else if (cmd.put_exec)
            begin
                if (put_scroll)
                begin
                    cur_reg <= AW'(BASE);
                    col_reg <= '0;
                end
                else if (is_lf)
                begin
                    cur_reg <= cur_reg + AW'(COLUMNS);
                end
                else if (is_cr)
                begin
                    cur_reg <= cur_reg - AW'(col_reg);
                    col_reg <= '0;
                end
                else
                begin
                    cur_reg <= cur_reg + AW'(1);
                    col_reg <= (col_reg == CLW'(COLUMNS - 1)) ? '0 : col_reg + CLW'(1);
                end
            end
            else if (cmd.set_apply)
            begin
                if (set_scroll)
                begin
                    cur_reg <= AW'(BASE);
                    col_reg <= '0;
                end
                else
                begin
                    cur_reg <= AW'(pos_reg);
                    col_reg <= rem;
                end
            end

            // one scroll per row the target lies below the bottom row
            if (cmd.put_exec && put_scroll)
            begin
                scroll_cnt_reg <= POS_W'(1);
            end
            else if (cmd.set_apply && set_scroll)
            begin
                scroll_cnt_reg <= quot - POS_W'(ROWS - 1);
            end
            else if (cmd.scroll_dec)
            begin
                scroll_cnt_reg <= scroll_cnt_reg - POS_W'(1);
            end

            if (cmd.capture)
            begin
                scrolled_reg <= 1'b0;
            end
            else if ((cmd.put_exec && put_scroll) || (cmd.set_apply && set_scroll))
            begin
                scrolled_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_addr_reg <= idx_reg;
        if (cmd.capture)
        begin
            func_reg  <= func_t'(func);
            char_reg  <= char_code;
            color_reg <= fill_color;
            pos_reg   <= position;
        end
        if (cmd.result_load)
        begin
            cursor_reg       <= CURSOR_W'(cur_reg);
            scrolled_out_reg <= scrolled_reg;
            if ((func_reg == FUNC_READ) && pos_in_range)
            begin
                cell_char_reg <= char_rdata;
                cell_attr_reg <= attr_rdata;
            end
            else
            begin
                cell_char_reg <= '0;
                cell_attr_reg <= '0;
            end
        end
    end

    assign cursor    = cursor_reg;
    assign cell_char = cell_char_reg;
    assign cell_attr = cell_attr_reg;
    assign scrolled  = scrolled_out_reg;

endmodule

[rtl/core/tcw_ctrl.sv]
// Controller state machine: sequences put, clear, set, read, scroll and the reset sweep.
module tcw_ctrl import tcw_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FUNC_W-1:0] func,
    input  dp_status_t        status,
    output dp_cmd_t           cmd,
    output logic              busy,
    output logic              done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_DIV,
        S_SET,
        S_READ,
        S_SWEEP,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    sweep_kind_t kind_reg;
    sweep_kind_t kind_next;
    logic        busy_reg;
    logic        done_reg;
    logic        accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cmd            = '0;
        cmd.sweep_kind = kind_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    unique case (func_t'(func))
                        FUNC_PUT:   state_next = S_PUT;
                        FUNC_CLEAR:
                        begin
                            kind_next  = SWEEP_CLEAR;
                            state_next = S_SWEEP;
                        end
                        FUNC_SET:   state_next = S_DIV;
                        FUNC_READ:  state_next = S_READ;
                    endcase
                end
            end
            S_PUT:
            begin
                cmd.put_exec = 1'b1;
                if (status.scroll_need)
                begin
                    kind_next  = SWEEP_SCROLL;
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_SET;
                end
            end
            S_SET:
            begin
                cmd.set_apply = 1'b1;
                if (status.scroll_need)
                begin
                    kind_next  = SWEEP_SCROLL;
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_SWEEP:
            begin
                cmd.sweep_run = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                unique case (kind_reg)
                    SWEEP_INIT:  state_next = S_IDLE;
                    SWEEP_CLEAR: state_next = S_DONE;
                    SWEEP_SCROLL:
                    begin
                        cmd.scroll_dec = 1'b1;
                        state_next     = status.scroll_more ? S_SWEEP : S_DONE;
                    end
                    default:     state_next = S_IDLE;
                endcase
            end
            S_DONE:
            begin
                cmd.result_load = 1'b1;
                state_next      = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            kind_reg  <= SWEEP_INIT;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            busy_reg  <= state_next != S_IDLE;
            done_reg  <= state_reg == S_DONE;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

[rtl/core/text_console_writer_top.sv]
// Top level of the text console writer: register port, controller and datapath.
// Clear and each scroll run a sweep over every cell of the screen.
// Throughput: one item at a time; busy stays high until the result beat is shown.
// Reset is asynchronous, active low; afterwards a clearing pass zeroes the screen with
// busy high. Results are not held off: done lasts one cycle.
module text_console_writer_top import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                clk,
    input  logic                rst_n,

    // command channel
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [ATTR_W-1:0]   fill_color,
    input  logic [POS_W-1:0]    position,

    // result channel
    output logic                done,
    output logic [CURSOR_W-1:0] cursor,
    output logic [CHAR_W-1:0]   cell_char,
    output logic [ATTR_W-1:0]   cell_attr,
    output logic                scrolled,

    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // register index comes from the word address bit
    localparam logic REG_SCROLL_FILL = 1'b0;

    logic [ATTR_W-1:0] fill_attr_reg;
    logic              reg_sel;
    dp_cmd_t           cmd;
    dp_status_t        status;

    assign reg_sel = paddr[2] == REG_SCROLL_FILL;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(32-ATTR_W){1'b0}}, fill_attr_reg} : '0;

    // Take a write at the access beat; other addresses drop the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_attr_reg <= FILL_ATTR_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            fill_attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    // Controller sequences every operation and the post-reset clearing pass.
    tcw_ctrl u_tcw_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .status(status),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Datapath owns the cursor, both screen memories and the result registers.
    tcw_dp #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_tcw_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .func            (func),
        .char_code       (char_code),
        .fill_color      (fill_color),
        .position        (position),
        .scroll_fill_attr(fill_attr_reg),
        .cursor          (cursor),
        .cell_char       (cell_char),
        .cell_attr       (cell_attr),
        .scrolled        (scrolled)
    );

endmodule

[rtl/core/tcw_checker.sv]
// Port-level checks of the text console writer and their bind to the top level.
module tcw_checker import tcw_pkg::*; #(
    parameter int CELLS = 2000
) (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [CURSOR_W-1:0] cursor
);

    localparam logic [31:0] CELLS_W32 = 32'(CELLS);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat shown while busy");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(cursor) < CELLS_W32))
        else $error("cursor beyond screen");

endmodule

bind text_console_writer_top tcw_checker #(
    .CELLS(COLUMNS * ROWS)
) u_tcw_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cursor(cursor)
);
